>>> design/efr_pkg.sv
// Shared types and constants for the escaped frame receiver.
`timescale 1ns / 1ps

package efr_pkg;

  // Framing bytes
  localparam logic [7:0] START_BYTE  = 8'h10;
  localparam logic [7:0] XOR_MASK    = 8'h11;
  localparam logic [7:0] ESCAPE_BYTE = 8'h20;

  // Result event codes
  localparam logic [1:0] EV_STORED = 2'd0;
  localparam logic [1:0] EV_GOOD   = 2'd1;
  localparam logic [1:0] EV_BAD    = 2'd2;
  localparam logic [1:0] EV_EMPTY  = 2'd3;

  // Receive phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_CMD   = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4
  } phase_t;

  // One result item
  typedef struct packed {
    logic [7:0] byte_value;
    logic [8:0] byte_index;
    logic [1:0] event_res;
  } efr_result_t;

endpackage

>>> design/escaped_frame_receiver.sv
// A byte accepted from in_* is held in the input register; its result is then registered
// in the result register, which drives out_*.
// Throughput: one byte per cycle; the input register and result register stall
// together only when the result register is full and not being taken.
// Escape bytes and idle noise use a slot but produce no result transaction.
// Reset (rst_n low, synchronous) empties both registers and returns to idle.
`timescale 1ns / 1ps

module escaped_frame_receiver
  import efr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [8:0] byte_index, [16:9] byte_value, [23:17] zero
  output logic [1:0]  out_tuser   // [1:0] event_res
);

  logic        advance;
  logic        byte_valid;
  logic [7:0]  rx_byte;
  logic        step;
  logic        res_valid;
  efr_result_t res;

  assign step = byte_valid && advance;

  efr_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .advance   (advance),
    .byte_valid(byte_valid),
    .rx_byte   (rx_byte)
  );

  efr_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .rx_byte  (rx_byte),
    .res_valid(res_valid),
    .res      (res)
  );

  efr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

>>> design/efr_in_stage.sv
// Input register stage: holds one received byte for the frame logic.
`timescale 1ns / 1ps

module efr_in_stage
  import efr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] rx_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  // Take a new byte whenever the held one is empty or moves on this cycle
  assign in_tready = !valid_r || advance;
  assign valid_nxt = in_tready ? in_tvalid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
    end
  end

  assign byte_valid = valid_r;
  assign rx_byte    = byte_r;

endmodule

>>> design/efr_core.sv
// Frame logic: unescaping, receive phase machine, checksum and result build.
`timescale 1ns / 1ps

module efr_core
  import efr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  output efr_result_t res
);

  phase_t     phase_r,   phase_nxt;
  logic       esc_r,     esc_nxt;
  logic [7:0] sum_r,     sum_nxt;
  logic [7:0] left_r,    left_nxt;
  logic [8:0] pos_r,     pos_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      esc_r   <= 1'b0;
      sum_r   <= '0;
      left_r  <= '0;
      pos_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      sum_r   <= sum_nxt;
      left_r  <= left_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Next state and result for the byte at hand
  always_comb begin
    logic [7:0] b;
    logic [7:0] left_dec;
    b         = esc_r ? (rx_byte ^ XOR_MASK) : rx_byte;
    left_dec  = left_r - 8'd1;
    phase_nxt = phase_r;
    esc_nxt   = 1'b0;
    sum_nxt   = sum_r;
    left_nxt  = left_r;
    pos_nxt   = pos_r;
    res_valid = 1'b0;
    res.event_res  = EV_STORED;
    res.byte_index = pos_r;
    res.byte_value = b;

    if (rx_byte == ESCAPE_BYTE) begin
      // escape marker: no result, next byte is unmasked
      esc_nxt = 1'b1;
    end else begin
      case (phase_r)
        PH_CMD: begin
          res_valid = 1'b1;
          sum_nxt   = sum_r + b;
          pos_nxt   = pos_r + 9'd1;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          res_valid = 1'b1;
          if (b == 8'd0) begin
            // empty frame is abandoned
            res.event_res = EV_EMPTY;
            phase_nxt     = PH_IDLE;
          end else begin
            left_nxt  = b;
            sum_nxt   = sum_r + b;
            pos_nxt   = pos_r + 9'd1;
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          res_valid = 1'b1;
          sum_nxt   = sum_r + b;
          pos_nxt   = pos_r + 9'd1;
          left_nxt  = left_dec;
          if (left_dec == 8'd0) begin
            phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          res_valid     = 1'b1;
          res.event_res = (b == sum_r) ? EV_GOOD : EV_BAD;
          phase_nxt     = PH_IDLE;
        end
        default: begin
          // idle: wait for the start byte, ignore noise
          phase_nxt = PH_IDLE;
          if (b == START_BYTE) begin
            res_valid      = 1'b1;
            res.byte_index = '0;
            sum_nxt        = b;
            pos_nxt        = 9'd1;
            phase_nxt      = PH_CMD;
          end
        end
      endcase
    end
  end

endmodule

>>> design/efr_out_stage.sv
// Result register stage: holds one result until the downstream side takes it.
`timescale 1ns / 1ps

module efr_out_stage
  import efr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic        res_valid,
  input  efr_result_t res,
  output logic        advance,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic [1:0]  out_tuser
);

  logic        valid_r;
  logic        valid_nxt;
  efr_result_t res_r;

  // Register frees up when empty or being drained this cycle
  assign advance   = !valid_r || out_tready;
  assign valid_nxt = advance ? (load && res_valid) : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load && res_valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {7'd0, res_r.byte_value, res_r.byte_index};
  assign out_tuser  = res_r.event_res;

endmodule

>>> design/efr_checker.sv
// Port-level checks for the escaped frame receiver, bound to the top level.
`timescale 1ns / 1ps

module efr_checker
  import efr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // Stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Empty frame verdict always sits at the length position with value zero
  a_empty_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == EV_EMPTY |-> out_tdata[8:0] == 9'd2 && out_tdata[16:9] == 8'd0)
    else $error("empty frame report malformed");

  // Stored byte at frame position zero is the start byte
  a_start_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == EV_STORED && out_tdata[8:0] == 9'd0
      |-> out_tdata[16:9] == START_BYTE)
    else $error("frame opened without start byte");

  // Padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:17] == 7'd0)
    else $error("nonzero padding in result");

endmodule

bind escaped_frame_receiver efr_checker u_efr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
